// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the voxel filter RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, masked while in reset.
`define VDPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same-cycle implication.
`define VDPF_ASSERT_IMP(lbl, ante, cons, msg) \
  `VDPF_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== rtl/vdpf_pkg.sv =====
// Shared constants, types and codes of the voxel dedup point filter.
// No dependencies; every RTL module imports this package.
package vdpf_pkg;

  localparam int CAPACITY    = 65536;
  localparam int TABLE_SLOTS = 131072;   // power of two
  localparam int AXIS_BITS   = 21;

  localparam int COORD_W = 32;
  localparam int VPM_W   = 32;
  localparam int CNT_W   = 17;
  localparam int PIDX_W  = 16;
  localparam int KEY_W   = 63;
  localparam int STAT_W  = 3;
  localparam int IDX_W   = $clog2(TABLE_SLOTS);

  // Slot index is bits [HASH_SHIFT +: IDX_W] of key * HASH_MUL, so only the
  // low HB bits of key and multiplier matter. Split in halves for the multiply.
  localparam int HASH_SHIFT = 20;
  localparam int HB         = HASH_SHIFT + IDX_W;
  localparam int HL         = (HB + 1) / 2;
  localparam int HU         = HB - HL;
  localparam logic [63:0]    HASH_MUL = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [HL-1:0]  HASH_C0  = HASH_MUL[HL-1:0];
  localparam logic [HU-1:0]  HASH_C1  = HASH_MUL[HB-1:HL];

  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);

  localparam int CFG_AW = 3;
  localparam logic REG_POINT_LIMIT = 1'b0;
  localparam logic REG_VPM         = 1'b1;
  localparam logic [CNT_W-1:0] POINT_LIMIT_RST = 17'd65536;
  localparam logic [VPM_W-1:0] VPM_RST         = 32'd655360;

  localparam logic [STAT_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_TAKEN   = 3'd1;
  localparam logic [STAT_W-1:0] ST_RANGE   = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STAT_W-1:0] ST_CLEARED = 3'd4;

  typedef enum logic [1:0] {
    K_ADD,
    K_RANGE,
    K_CLEAR
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic [KEY_W-1:0]          key;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } qent_t;

  typedef struct packed {
    logic [CNT_W-1:0] point_limit;
    logic [VPM_W-1:0] vpm;
  } cfg_t;

endpackage

// ===== rtl/vdpf_cfg.sv =====
// Configuration registers behind the APB-style port.
// Depends on vdpf_pkg.
module vdpf_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [vdpf_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready,
  output vdpf_pkg::cfg_t             cfg
);
  import vdpf_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr;
  logic sel;

  assign cfg_pready = 1'b1;
  assign wr  = cfg_psel & cfg_penable & cfg_pwrite;
  assign sel = cfg_paddr[CFG_AW-1];
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (sel)
        REG_POINT_LIMIT: cfg_nxt.point_limit = cfg_pwdata[CNT_W-1:0];
        default:         cfg_nxt.vpm         = cfg_pwdata[VPM_W-1:0];
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_POINT_LIMIT: cfg_prdata = {{(32-CNT_W){1'b0}}, cfg_r.point_limit};
      default:         cfg_prdata = cfg_r.vpm;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.point_limit <= POINT_LIMIT_RST;
      cfg_r.vpm         <= VPM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/vdpf_front.sv =====
// Front end: takes input beats, scales each axis to a voxel coordinate,
// forms the key and its slot hash, and pushes a classified entry. Uses vdpf_pkg.
module vdpf_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [95:0]                  in_tdata,   // x, y, z
  input  logic [0:0]                   in_tuser,   // mode
  input  vdpf_pkg::cfg_t               cfg,
  input  logic                         sweeping,
  input  logic                         full,
  output logic                         push,
  output vdpf_pkg::qent_t              push_ent
);
  import vdpf_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SCALE,
    F_HASH,
    F_PUSH
  } fstate_t;

  localparam logic [1:0] LAST_STEP = 2'd3;

  fstate_t state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  kind_t kind_r, kind_nxt;
  logic signed [COORD_W-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic rng_ok_r, rng_ok_nxt;
  logic [HB-1:0] pp0_r, pp0_nxt, pp1_r, pp1_nxt, pp2_r, pp2_nxt;

  logic signed [COORD_W-1:0] coord_sel;
  logic signed [VPM_W:0]     scale_s;
  logic signed [64:0]        prod_full;
  logic [31:0]               vox;
  logic [31-AXIS_BITS+1:0]   vox_hi;
  logic                      ax_ok;
  logic [AXIS_BITS-1:0]      field;
  logic [HL-1:0]             ha;
  logic [HU-1:0]             hb;
  logic [2*HL-1:0]           m0;
  logic [HB-1:0]             m1, m2;
  logic [HB-1:0]             hsum;
  logic                      accept;

  assign in_tready = (state_r == F_IDLE) && !sweeping;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    case (cnt_r)
      2'd0:    coord_sel = x_r;
      2'd1:    coord_sel = y_r;
      default: coord_sel = z_r;
    endcase
  end

  assign scale_s   = signed'({1'b0, cfg.vpm});
  assign prod_full = coord_sel * scale_s;

  // Upper half of the exact product is the floored voxel coordinate.
  assign vox    = prod_r[63:32];
  assign vox_hi = vox[31:AXIS_BITS-1];
  assign ax_ok  = (&vox_hi) | (~|vox_hi);
  assign field  = {~vox[AXIS_BITS-1], vox[AXIS_BITS-2:0]};

  assign ha = key_r[HL-1:0];
  assign hb = key_r[HB-1:HL];
  assign m0 = ha * HASH_C0;
  assign m1 = ha * HASH_C1;
  assign m2 = hb * HASH_C0;
  assign hsum = pp0_r + ((pp1_r + pp2_r) << HL);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    kind_nxt   = kind_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    z_nxt      = z_r;
    prod_nxt   = prod_r;
    key_nxt    = key_r;
    rng_ok_nxt = rng_ok_r;
    pp0_nxt    = pp0_r;
    pp1_nxt    = pp1_r;
    pp2_nxt    = pp2_r;
    push       = 1'b0;
    push_ent.kind = kind_r;
    push_ent.key  = key_r;
    push_ent.idx  = hsum[HB-1:HASH_SHIFT];
    push_ent.x    = x_r;
    push_ent.y    = y_r;
    push_ent.z    = z_r;

    case (state_r)
      F_IDLE: begin
        if (accept) begin
          x_nxt      = in_tdata[31:0];
          y_nxt      = in_tdata[63:32];
          z_nxt      = in_tdata[95:64];
          key_nxt    = '0;
          rng_ok_nxt = 1'b1;
          cnt_nxt    = 2'd0;
          if (in_tuser[0]) begin
            kind_nxt  = K_CLEAR;
            state_nxt = F_PUSH;
          end else begin
            kind_nxt  = K_ADD;
            state_nxt = F_SCALE;
          end
        end
      end
      F_SCALE: begin
        // multiply one axis while checking the previous one
        if (cnt_r != LAST_STEP) begin
          prod_nxt = prod_full[63:0];
        end
        if (cnt_r != 2'd0) begin
          rng_ok_nxt = rng_ok_r & ax_ok;
        end
        case (cnt_r)
          2'd1:    key_nxt[0 +: AXIS_BITS]           = field;
          2'd2:    key_nxt[AXIS_BITS +: AXIS_BITS]   = field;
          2'd3:    key_nxt[2*AXIS_BITS +: AXIS_BITS] = field;
          default: ;
        endcase
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == LAST_STEP) begin
          if (rng_ok_r & ax_ok) begin
            state_nxt = F_HASH;
          end else begin
            kind_nxt  = K_RANGE;
            state_nxt = F_PUSH;
          end
        end
      end
      F_HASH: begin
        pp0_nxt   = m0[HB-1:0];
        pp1_nxt   = m1;
        pp2_nxt   = m2;
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!full) begin
          push      = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    kind_r   <= kind_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    z_r      <= z_nxt;
    prod_r   <= prod_nxt;
    key_r    <= key_nxt;
    rng_ok_r <= rng_ok_nxt;
    pp0_r    <= pp0_nxt;
    pp1_r    <= pp1_nxt;
    pp2_r    <= pp2_nxt;
  end

endmodule

// ===== rtl/vdpf_fifo.sv =====
// Short entry queue between the front end and the table engine.
// Depends on vdpf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module vdpf_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  vdpf_pkg::qent_t push_ent,
  output logic            full,
  input  logic            pop,
  output vdpf_pkg::qent_t head,
  output logic            empty
);
  import vdpf_pkg::*;

  qent_t ent_r [QDEPTH];
  logic [QPW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QPW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QPW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop  ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QPW+1)'(push) - (QPW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_ent;
    end
  end

  `VDPF_ASSERT_IMP(a_push_room, push, !full, "entry pushed into a full queue")
  `VDPF_ASSERT_IMP(a_pop_data, pop, !empty, "entry popped from an empty queue")

endmodule

// ===== rtl/vdpf_back.sv =====
// Table engine: owns the occupied-voxel table and the kept count, probes
// linearly from the hashed slot and drives the result register. Uses vdpf_pkg.
`include "assert_macros.svh"
module vdpf_back (
  input  logic            clk,
  input  logic            rst_n,
  input  vdpf_pkg::cfg_t  cfg,
  input  vdpf_pkg::qent_t head,
  input  logic            empty,
  output logic            pop,
  output logic            sweeping,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [191:0]    out_tdata,   // voxel_key, point_index, point_count, x, y, z
  output logic [3:0]      out_tuser    // accepted, status
);
  import vdpf_pkg::*;

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_PROBE
  } bstate_t;

  logic [63:0] vox_mem [TABLE_SLOTS];
  logic [63:0] slot_r;

  bstate_t state_r, state_nxt;
  logic [IDX_W-1:0] sweep_r, sweep_nxt, idx_r, idx_nxt, probe_r, probe_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic signed [COORD_W-1:0] px_r, px_nxt, py_r, py_nxt, pz_r, pz_nxt;
  logic [CNT_W-1:0] kept_r, kept_nxt;

  logic                      oval_r, oval_nxt;
  logic                      oacc_r;
  logic [STAT_W-1:0]         ostat_r;
  logic [KEY_W-1:0]          okey_r;
  logic [PIDX_W-1:0]         oidx_r;
  logic [CNT_W-1:0]          ocnt_r;
  logic signed [COORD_W-1:0] ox_r, oy_r, oz_r;

  logic                      load;
  logic                      res_acc;
  logic [STAT_W-1:0]         res_stat;
  logic [KEY_W-1:0]          res_key;
  logic [PIDX_W-1:0]         res_idx;
  logic [CNT_W-1:0]          res_cnt;
  logic signed [COORD_W-1:0] res_x, res_y, res_z;

  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic [63:0]       wr_data;
  logic              out_free, blocked;

  assign out_free = !oval_r || out_tready;
  assign sweeping = (state_r == S_SWEEP);
  assign blocked  = (cfg.point_limit == '0) || (cfg.vpm == '0) ||
                    (kept_r >= cfg.point_limit) || (32'(kept_r) >= 32'(CAPACITY));

  assign out_tvalid = oval_r;
  assign out_tdata  = {oz_r, oy_r, ox_r, ocnt_r, oidx_r, okey_r};
  assign out_tuser  = {ostat_r, oacc_r};

  always_comb begin
    state_nxt = state_r;
    sweep_nxt = sweep_r;
    idx_nxt   = idx_r;
    probe_nxt = probe_r;
    key_nxt   = key_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    pz_nxt    = pz_r;
    kept_nxt  = kept_r;
    pop       = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = idx_r + 1'b1;
    wr_en     = 1'b0;
    wr_addr   = sweep_r;
    wr_data   = '0;
    load      = 1'b0;
    res_acc   = 1'b0;
    res_stat  = ST_FULL;
    res_key   = '0;
    res_idx   = '0;
    res_cnt   = kept_r;
    res_x     = '0;
    res_y     = '0;
    res_z     = '0;

    case (state_r)
      S_SWEEP: begin
        wr_en     = 1'b1;
        sweep_nxt = sweep_r + 1'b1;
        if (&sweep_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!empty && out_free) begin
          pop = 1'b1;
          case (head.kind)
            K_CLEAR: begin
              load      = 1'b1;
              res_stat  = ST_CLEARED;
              res_cnt   = '0;
              kept_nxt  = '0;
              sweep_nxt = '0;
              state_nxt = S_SWEEP;
            end
            default: begin
              if (blocked) begin
                load     = 1'b1;
                res_stat = ST_FULL;
              end else if (head.kind == K_RANGE) begin
                load     = 1'b1;
                res_stat = ST_RANGE;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = head.idx;
                idx_nxt   = head.idx;
                probe_nxt = '0;
                key_nxt   = head.key;
                px_nxt    = head.x;
                py_nxt    = head.y;
                pz_nxt    = head.z;
                state_nxt = S_PROBE;
              end
            end
          endcase
        end
      end
      S_PROBE: begin
        res_key = key_r;
        if (!slot_r[63]) begin
          wr_en     = 1'b1;
          wr_addr   = idx_r;
          wr_data   = {1'b1, key_r};
          load      = 1'b1;
          res_acc   = 1'b1;
          res_stat  = ST_ADDED;
          res_idx   = kept_r[PIDX_W-1:0];
          res_cnt   = kept_r + 1'b1;
          res_x     = px_r;
          res_y     = py_r;
          res_z     = pz_r;
          kept_nxt  = kept_r + 1'b1;
          state_nxt = S_IDLE;
        end else if (slot_r[KEY_W-1:0] == key_r) begin
          load      = 1'b1;
          res_stat  = ST_TAKEN;
          state_nxt = S_IDLE;
        end else if (&probe_r) begin
          // wrapped all the way round: no free slot
          load      = 1'b1;
          res_stat  = ST_FULL;
          state_nxt = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          idx_nxt   = idx_r + 1'b1;
          probe_nxt = probe_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    oval_nxt = load ? 1'b1 : (out_tready ? 1'b0 : oval_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
      sweep_r <= '0;
      kept_r  <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      kept_r  <= kept_nxt;
      oval_r  <= oval_nxt;
    end
    idx_r   <= idx_nxt;
    probe_r <= probe_nxt;
    key_r   <= key_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    pz_r    <= pz_nxt;
    if (load) begin
      oacc_r  <= res_acc;
      ostat_r <= res_stat;
      okey_r  <= res_key;
      oidx_r  <= res_idx;
      ocnt_r  <= res_cnt;
      ox_r    <= res_x;
      oy_r    <= res_y;
      oz_r    <= res_z;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vox_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      slot_r <= vox_mem[rd_addr];
    end
  end

  `VDPF_ASSERT_IMP(a_no_pop_in_sweep, state_r == S_SWEEP, !pop, "entry taken during sweep")
  `VDPF_ASSERT_IMP(a_load_free, load, out_free, "result overwrote an untaken beat")
  `VDPF_ASSERT(a_kept_step, (load && res_acc) |=> (kept_r == $past(kept_r) + 1'b1), "kept count did not step on add")

endmodule

// ===== rtl/voxel_dedup_point_filter_top.sv =====
// A point passes the front end's scale steps, hash stage and push, then the entry queue,
// then the table engine's read of its hashed slot and of each further slot probed; a clear
// beat skips the scale steps and hash stage. The front end takes a new point only after
// pushing the last one, as its scaling multiplier is shared by all three axes.
// Reset: synchronous, active low; the 131072-slot voxel table is then swept empty, one
// slot a cycle, and the same sweep follows each clear; no input beat is taken meanwhile.
module voxel_dedup_point_filter_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [95:0]                 in_tdata,    // x [31:0], y [63:32], z [95:64]
  input  logic [0:0]                  in_tuser,    // mode
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [191:0]                out_tdata,   // voxel_key, point_index, point_count,
                                                   // out_x, out_y, out_z
  output logic [3:0]                  out_tuser,   // accepted, status
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [vdpf_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import vdpf_pkg::*;

  cfg_t  cfg;
  qent_t push_ent, head;
  logic  push, pop, full, empty, sweeping;

  vdpf_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  vdpf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg       (cfg),
    .sweeping  (sweeping),
    .full      (full),
    .push      (push),
    .push_ent  (push_ent)
  );

  vdpf_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  vdpf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .sweeping   (sweeping),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
